### hdl/card_and_pin_access_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the card and PIN access checker
// Shared shorthand for clocked checks, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CARD_AND_PIN_ACCESS_CHECK_ASSERT_SVH
`define CARD_AND_PIN_ACCESS_CHECK_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset
`define CPAC_CHECK(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger in one cycle is followed by a condition in the next
`define CPAC_CHECK_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/cpac_pkg.sv
// ----------------------------------------------------------------------------
// cpac_pkg
// Types and constants shared by the card and PIN access checker modules.
// ----------------------------------------------------------------------------
package cpac_pkg;

    // Register and field widths
    localparam int ID_W      = 48;
    localparam int KEY_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARD_ID_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASSKEY_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PASSKEY_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PASSKEY_C = 3'd5;

    // Register reset values
    localparam logic [ID_W-1:0]  CARD_ID_A_RST = 48'h254006A1498B;
    localparam logic [ID_W-1:0]  CARD_ID_B_RST = 48'h160066BD7AB7;
    localparam logic [ID_W-1:0]  CARD_ID_C_RST = 48'h160066203060;
    localparam logic [KEY_W-1:0] PASSKEY_A_RST = 16'h1704;
    localparam logic [KEY_W-1:0] PASSKEY_B_RST = 16'h4202;
    localparam logic [KEY_W-1:0] PASSKEY_C_RST = 16'h4203;

    // ASCII codes bounding the uppercase hex digits
    localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_F = 8'h46;

    // Input command codes
    localparam logic CMD_CARD = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Item class decided by the front end
    typedef enum logic [1:0] {
        KIND_CARD_HEX,
        KIND_CARD_OTHER,
        KIND_KEY
    } item_kind_t;

    // Classified word carried through the queue
    typedef struct packed {
        item_kind_t         kind;
        logic [NIB_W-1:0]   nib;
    } item_t;

    typedef enum logic [1:0] {
        OUT_GRANTED = 2'd0,
        OUT_WRONG   = 2'd1,
        OUT_UNKNOWN = 2'd2
    } outcome_t;

    typedef enum logic {
        PH_CARD,
        PH_KEYS
    } phase_t;

endpackage

### hdl/cpac_front.sv
// ----------------------------------------------------------------------------
// cpac_front
// Classifies each incoming word: hex card byte with its digit value,
// other card byte, or key press with its code.
// ----------------------------------------------------------------------------
module cpac_front import cpac_pkg::*;
(
    input  logic                command,
    input  logic [BYTE_W-1:0]   card_byte,
    input  logic [NIB_W-1:0]    key_code,
    output item_t               item
);

    logic is_digit;
    logic is_letter;

    // Decode uppercase ASCII hex
    assign is_digit  = (card_byte >= ASCII_ZERO) && (card_byte <= ASCII_NINE);
    assign is_letter = (card_byte >= ASCII_UPPER_A) && (card_byte <= ASCII_UPPER_F);

    // Build the classified word
    always_comb
    begin
        item.kind = KIND_CARD_OTHER;
        item.nib  = '0;
        if (command == CMD_KEY)
        begin
            item.kind = KIND_KEY;
            item.nib  = key_code;
        end
        else if (is_digit)
        begin
            item.kind = KIND_CARD_HEX;
            item.nib  = card_byte[NIB_W-1:0];
        end
        else if (is_letter)
        begin
            item.kind = KIND_CARD_HEX;
            item.nib  = card_byte[NIB_W-1:0] + 4'd9;
        end
    end

endmodule

### hdl/cpac_queue.sv
// ----------------------------------------------------------------------------
// cpac_queue
// Two-entry queue of classified words between front end and back end.
// ----------------------------------------------------------------------------
module cpac_queue import cpac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output item_t   head
);

    item_t          slot_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/cpac_back.sv
// ----------------------------------------------------------------------------
// cpac_back
// Holds the card numbers and passkeys, steps the card and key phases one
// word per cycle unless an untaken result stalls it, and keeps the result word in an output register.
// ----------------------------------------------------------------------------
`include "card_and_pin_access_check_assert.svh"

module cpac_back import cpac_pkg::*;
#(
    parameter int ID_CHARS  = 12,
    parameter int PASS_KEYS = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ID_W-1:0]         cfg_data,
    input  logic                    q_valid,
    input  item_t                   q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output outcome_t                out_outcome,
    output logic [1:0]              out_entry
);

    localparam int CNT_W  = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
    localparam int KCNT_W = (PASS_KEYS > 1) ? $clog2(PASS_KEYS) : 1;

    // Configuration registers
    logic [ID_W-1:0]        card_id_reg [3];
    logic [KEY_W-1:0]       passkey_reg [3];

    // Phase state and counters
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [CNT_W-1:0]       char_cnt_reg;
    logic [CNT_W-1:0]       char_cnt_next;
    logic [2:0]             card_match_reg;
    logic [2:0]             card_match_next;
    logic [1:0]             entry_sel_reg;
    logic [1:0]             entry_sel_next;
    logic [KCNT_W-1:0]      key_cnt_reg;
    logic [KCNT_W-1:0]      key_cnt_next;
    logic                   key_ok_reg;
    logic                   key_ok_next;

    // Output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    outcome_t               outcome_reg;
    logic [1:0]             entry_reg;

    // Step decode
    logic [15:0][3:0]       id_nibs [3];
    logic [3:0][3:0]        pk_nibs;
    logic [3:0]             id_sel;
    logic [1:0]             key_sel;
    logic [2:0]             hit;
    logic [2:0]             cand;
    logic [1:0]             first_hit;
    logic                   last_char;
    logic                   last_key;
    logic                   key_hit;
    logic                   emit;
    outcome_t               emit_outcome;
    logic [1:0]             emit_entry;

    assign q_pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_outcome = outcome_reg;
    assign out_entry   = entry_reg;

    // Pick the nibble under test in each register
    assign id_sel  = 4'(ID_CHARS - 1) - 4'(char_cnt_reg);
    assign key_sel = 2'(PASS_KEYS - 1) - 2'(key_cnt_reg);
    assign pk_nibs = passkey_reg[entry_sel_reg];

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            id_nibs[e] = 64'(card_id_reg[e]);
            hit[e]     = (q_item.kind == KIND_CARD_HEX) && (q_item.nib == id_nibs[e][id_sel]);
        end
    end

    assign cand      = card_match_reg & hit;
    assign first_hit = cand[0] ? 2'd0 : (cand[1] ? 2'd1 : 2'd2);
    assign last_char = (char_cnt_reg == CNT_W'(ID_CHARS - 1));
    assign last_key  = (key_cnt_reg == KCNT_W'(PASS_KEYS - 1));
    assign key_hit   = (q_item.nib == pk_nibs[key_sel]);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_id_reg[0] <= CARD_ID_A_RST;
            card_id_reg[1] <= CARD_ID_B_RST;
            card_id_reg[2] <= CARD_ID_C_RST;
            passkey_reg[0] <= PASSKEY_A_RST;
            passkey_reg[1] <= PASSKEY_B_RST;
            passkey_reg[2] <= PASSKEY_C_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CARD_ID_A: card_id_reg[0] <= cfg_data;
                REG_CARD_ID_B: card_id_reg[1] <= cfg_data;
                REG_CARD_ID_C: card_id_reg[2] <= cfg_data;
                REG_PASSKEY_A: passkey_reg[0] <= cfg_data[KEY_W-1:0];
                REG_PASSKEY_B: passkey_reg[1] <= cfg_data[KEY_W-1:0];
                REG_PASSKEY_C: passkey_reg[2] <= cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
        begin
            case (phase_reg)
                PH_CARD:
                begin
                    if (q_item.kind != KIND_KEY && last_char && cand != 3'd0)
                    begin
                        phase_next = PH_KEYS;
                    end
                end
                PH_KEYS:
                begin
                    if (q_item.kind == KIND_KEY && last_key)
                    begin
                        phase_next = PH_CARD;
                    end
                end
                default: phase_next = PH_CARD;
            endcase
        end
    end

    // Counters, match flags and result per phase
    always_comb
    begin
        char_cnt_next   = char_cnt_reg;
        card_match_next = card_match_reg;
        entry_sel_next  = entry_sel_reg;
        key_cnt_next    = key_cnt_reg;
        key_ok_next     = key_ok_reg;
        emit            = 1'b0;
        emit_outcome    = OUT_GRANTED;
        emit_entry      = 2'd0;
        if (q_pop)
        begin
            case (phase_reg)
                PH_CARD:
                begin
                    if (q_item.kind != KIND_KEY)
                    begin
                        if (last_char)
                        begin
                            char_cnt_next   = '0;
                            card_match_next = '1;
                            key_cnt_next    = '0;
                            key_ok_next     = 1'b1;
                            if (cand == 3'd0)
                            begin
                                emit         = 1'b1;
                                emit_outcome = OUT_UNKNOWN;
                            end
                            else
                            begin
                                entry_sel_next = first_hit;
                            end
                        end
                        else
                        begin
                            char_cnt_next   = char_cnt_reg + CNT_W'(1);
                            card_match_next = cand;
                        end
                    end
                end
                PH_KEYS:
                begin
                    if (q_item.kind == KIND_KEY)
                    begin
                        if (last_key)
                        begin
                            emit         = 1'b1;
                            emit_outcome = (key_ok_reg && key_hit) ? OUT_GRANTED : OUT_WRONG;
                            emit_entry   = entry_sel_reg;
                            key_cnt_next = '0;
                            key_ok_next  = 1'b1;
                        end
                        else
                        begin
                            key_cnt_next = key_cnt_reg + KCNT_W'(1);
                            key_ok_next  = key_ok_reg && key_hit;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CARD;
            char_cnt_reg   <= '0;
            card_match_reg <= '1;
            entry_sel_reg  <= 2'd0;
            key_cnt_reg    <= '0;
            key_ok_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            char_cnt_reg   <= char_cnt_next;
            card_match_reg <= card_match_next;
            entry_sel_reg  <= entry_sel_next;
            key_cnt_reg    <= key_cnt_next;
            key_ok_reg     <= key_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            outcome_reg <= emit_outcome;
            entry_reg   <= emit_entry;
        end
    end

    `CPAC_CHECK(a_char_cnt_range, char_cnt_reg <= CNT_W'(ID_CHARS - 1), "card byte count out of range")
    `CPAC_CHECK(a_keys_clean_in_card, phase_reg == PH_KEYS || key_cnt_reg == '0, "key count set during card phase")
    `CPAC_CHECK(a_chars_clean_in_keys, phase_reg == PH_CARD || char_cnt_reg == '0, "card count set during key phase")
    `CPAC_CHECK(a_no_pop_on_stall, !(out_valid_reg && !out_ready && q_pop), "queue popped while result stalled")
    `CPAC_CHECK_NEXT(a_emit_shows, q_pop && emit, out_valid_reg, "result word lost")
    `CPAC_CHECK(a_unknown_entry_zero, !(out_valid_reg && outcome_reg == OUT_UNKNOWN) || entry_reg == 2'd0, "unknown card with nonzero entry")

endmodule

### hdl/card_and_pin_access_check.sv
// ----------------------------------------------------------------------------
// card_and_pin_access_check
// Card plus passkey access checker. Card reader bytes and keypad key codes
// arrive as words on one input channel. After ID_CHARS card bytes the card
// is compared, as uppercase ASCII hex, with three configured card numbers,
// lowest entry first; no match gives an unknown card result. After a match
// PASS_KEYS key presses are compared with that entry's passkey and the block
// reports granted or wrong passkey. Keys during card entry and card bytes
// during key entry are dropped without a result. Throughput is one word per
// clock: the front end classifies each word into a two-entry queue and the
// back end matches one word per cycle against all three entries at once.
// A result is registered: the word that completes it passes through the queue
// and then sets the output register, where the result is held until taken;
// a stalled output stops the back end, and the queue keeps accepting until
// it is full. The user must write registers on the plain write port only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module card_and_pin_access_check import cpac_pkg::*;
#(
    parameter int ID_CHARS  = 12,
    parameter int PASS_KEYS = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ID_W-1:0]         cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [BYTE_W-1:0]       card_byte,
    input  logic [NIB_W-1:0]        key_code,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              outcome,
    output logic [1:0]              entry
);

    item_t      front_item;
    item_t      head_item;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    outcome_t   back_outcome;

    assign in_ready = !q_full;
    assign outcome  = back_outcome;

    // Classify incoming words
    cpac_front u_front
    (
        .command    (command),
        .card_byte  (card_byte),
        .key_code   (key_code),
        .item       (front_item)
    );

    // Decouple front and back
    cpac_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !q_full),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head_item)
    );

    // Match and report
    cpac_back #(
        .ID_CHARS   (ID_CHARS),
        .PASS_KEYS  (PASS_KEYS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_outcome (back_outcome),
        .out_entry   (entry)
    );

endmodule
